FILE: sv/piba_pkg.sv
// piba_pkg: shared widths and the search token type for the block allocator
// used by piba_cell and parent_id_block_allocator_core; no dependencies
`default_nettype none

package piba_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned LBA_W = 32;

  // search token handed from one cell to the next
  typedef struct packed {
    logic             hit;
    logic [LBA_W-1:0] found;
  } token_t;

endpackage

`default_nettype wire

FILE: sv/piba_cell.sv
// piba_cell: one table entry of the allocator chain plus one stage of the
// search token pipeline; depends on piba_pkg
`default_nettype none

module piba_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          shift_i,     // take the neighbor's entry
  input  wire                          occupied_i,  // entry index below the count
  input  wire  [piba_pkg::KEY_W-1:0]   query_id_i,
  input  wire  [piba_pkg::KEY_W-1:0]   key_i,
  input  wire  [piba_pkg::LBA_W-1:0]   lba_i,
  input  wire  piba_pkg::token_t       tok_i,
  output logic [piba_pkg::KEY_W-1:0]   key_o,
  output logic [piba_pkg::LBA_W-1:0]   lba_o,
  output piba_pkg::token_t             tok_o
);

  logic [piba_pkg::KEY_W-1:0] key_q;
  logic [piba_pkg::LBA_W-1:0] lba_q;
  logic                       hit_q, hit_d;
  logic [piba_pkg::LBA_W-1:0] found_q, found_d;
  logic                       match;

  // entry storage, shifted down the chain on insert
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= key_i;
      lba_q <= lba_i;
    end
  end

  // compare against the query and merge with the upstream token
  always_comb begin
    match   = occupied_i && (key_q == query_id_i);
    hit_d   = tok_i.hit || match;
    found_d = tok_i.hit ? tok_i.found : lba_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
  end

  assign key_o       = key_q;
  assign lba_o       = lba_q;
  assign tok_o.hit   = hit_q;
  assign tok_o.found = found_q;

endmodule

`default_nettype wire

FILE: sv/parent_id_block_allocator_core.sv
// parent_id_block_allocator_core: lookup-or-insert table of dir id / block
// pairs built as a chain of piba_cell; depends on piba_pkg and piba_cell
//
//   channel   dir  tdata                              tuser
//   s_axis    in   [31:0] dir_id, [63:32] next_lba    [0] is_root
//   m_axis    out  [31:0] assigned_lba                [0] lba_consumed, [1] table_full
//
// the search token walks the cell chain one cell per cycle in the search state,
// then the write state decides and inserts and the block returns to idle; a new
// item is taken only in idle, so one item is in flight at a time. the result sits
// in an output register, so the next item is taken while it waits; a stalled
// output only holds the write state.
// reset clears the entry count and control state; no clearing pass is needed.
`default_nettype none

module parent_id_block_allocator_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [63:0] s_axis_tdata_i,   // [31:0] dir_id, [63:32] next_lba
  input  wire  [0:0]  s_axis_tuser_i,   // [0] is_root
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] assigned_lba
  output logic [1:0]  m_axis_tuser_o    // [0] lba_consumed, [1] table_full
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SRC_W = $clog2(TABLE_DEPTH);
  localparam int unsigned KW    = piba_pkg::KEY_W;
  localparam int unsigned LW    = piba_pkg::LBA_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } state_e;

  state_e           state_q;
  logic [SRC_W-1:0] step_q;
  logic [CNT_W-1:0] entry_cnt_q;
  logic [KW-1:0]    id_q;
  logic [LW-1:0]    lba_q;
  logic             root_q;
  logic             out_vld_q;
  logic [LW-1:0]    out_lba_q;
  logic             out_cons_q;
  logic             out_full_q;

  logic             in_xfer;
  logic             out_free;
  logic             decide;
  logic             miss_store;
  logic             shift;
  logic             is_full;

  logic [TABLE_DEPTH-1:0] occupied;
  logic [KW-1:0]          key_out [TABLE_DEPTH];
  logic [LW-1:0]          lba_out [TABLE_DEPTH];
  piba_pkg::token_t       tok_out [TABLE_DEPTH];
  piba_pkg::token_t       tok_head;
  piba_pkg::token_t       tok_tail;

  // handshake and decide conditions
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign decide     = (state_q == ST_WRITE) && out_free;
  assign tok_tail   = tok_out[TABLE_DEPTH-1];
  assign is_full    = (entry_cnt_q == CNT_W'(TABLE_DEPTH));
  assign miss_store = !tok_tail.hit && !root_q;
  assign shift      = decide && miss_store && !is_full;

  assign tok_head.hit   = 1'b0;
  assign tok_head.found = '0;

  // cell chain: entries shift down on insert, token walks one cell per cycle
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (entry_cnt_q > CNT_W'(i));

    if (i == 0) begin : g_head
      piba_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (shift),
        .occupied_i (occupied[i]),
        .query_id_i (id_q),
        .key_i      (id_q),
        .lba_i      (lba_q),
        .tok_i      (tok_head),
        .key_o      (key_out[i]),
        .lba_o      (lba_out[i]),
        .tok_o      (tok_out[i])
      );
    end else begin : g_body
      piba_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (shift),
        .occupied_i (occupied[i]),
        .query_id_i (id_q),
        .key_i      (key_out[i-1]),
        .lba_i      (lba_out[i-1]),
        .tok_i      (tok_out[i-1]),
        .key_o      (key_out[i]),
        .lba_o      (lba_out[i]),
        .tok_o      (tok_out[i])
      );
    end
  end

  // sequencer, entry count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      entry_cnt_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      // result drains unless a new one takes its place
      if (out_vld_q && m_axis_tready_i && !decide) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_SEARCH;
            step_q  <= '0;
          end
        end
        ST_SEARCH: begin
          step_q <= step_q + SRC_W'(1);
          if (step_q == SRC_W'(TABLE_DEPTH - 1)) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state_q   <= ST_IDLE;
            out_vld_q <= 1'b1;
            if (shift) begin
              entry_cnt_q <= entry_cnt_q + CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // held query and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      id_q   <= s_axis_tdata_i[KW-1:0];
      lba_q  <= s_axis_tdata_i[KW+LW-1:KW];
      root_q <= s_axis_tuser_i[0];
    end
    if (decide) begin
      out_lba_q  <= tok_tail.hit ? tok_tail.found : lba_q;
      out_cons_q <= !tok_tail.hit;
      out_full_q <= miss_store && is_full;
    end
  end

  assign s_axis_tready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = out_lba_q;
  assign m_axis_tuser_o[0] = out_cons_q;
  assign m_axis_tuser_o[1] = out_full_q;

endmodule

`default_nettype wire

FILE: sv/piba_checker.sv
// piba_checker: port-level checks on the block allocator over time, bound
// to parent_id_block_allocator_core; no package dependency
`default_nettype none

module piba_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [31:0] m_axis_tdata_o,
  input wire [1:0]  m_axis_tuser_o
);

  // a full table is only reported on a miss that consumed the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("table_full without lba_consumed");

  // one item at a time: no input transfer in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in search");

  // a new result appears only as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result appeared while still busy");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind parent_id_block_allocator_core piba_checker u_piba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
